// ===== hw/rtl/dctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctd_pkg: shared definitions for the divisor counter
// Holds the default value width, the count field width and limit, and the
// status bundle that the remainder unit returns to the sequencer.
// ----------------------------------------------------------------------------
package dctd_pkg;

    // Default width of the value that is examined.
    localparam int VALUE_WIDTH_DEF = 31;

    // Width of the count fields and the value at which they saturate.
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Status of the iterative remainder unit.
    typedef struct packed {
        logic busy;   // A division is in progress.
        logic done;   // One-cycle pulse: the remainder is ready.
        logic zero;   // The remainder is zero (valid with done).
    } t_rem_stat;

endpackage

// ===== hw/rtl/dctd_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctd_rem: iterative restoring remainder unit
// Computes dividend mod divisor one dividend bit per cycle, most significant
// bit first, and reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module dctd_rem #(
    parameter int VALUE_WIDTH = dctd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output dctd_pkg::t_rem_stat    o_stat
);
    import dctd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH-1:0] n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, i_divisor};
        if (shifted >= {1'b0, i_divisor}) begin
            n_rem = diff[VALUE_WIDTH-1:0];
        end else begin
            n_rem = shifted[VALUE_WIDTH-1:0];
        end
    end

    // Control: bit counter, busy and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

    // A start always launches a division on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("remainder unit did not go busy after start");

    // The done pulse marks the end of a division, never its middle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while still busy");

    // Done is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

endmodule

// ===== hw/rtl/divisor_count_trial_division.sv =====
`timescale 1ns / 1ps
// Each trial divisor takes a square check and one pass of the bit-serial remainder unit.
// Throughput: one item at a time; a new item can be taken in the cycle after the previous result
// has moved into the output register, which may still be waiting to be taken.
// Reset (synchronous, active low) empties the output register and returns the
// sequencer to idle.
// ----------------------------------------------------------------------------
// divisor_count_trial_division: divisor counter by trial division
// Tries every candidate i while i*i does not exceed the value, using a shared
// iterative remainder unit, and returns the count, the count minus one and a
// prime flag.
// ----------------------------------------------------------------------------
module divisor_count_trial_division #(
    parameter int VALUE_WIDTH = dctd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [VALUE_WIDTH-1:0]       i_n_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dctd_pkg::COUNT_W-1:0] o_divisor_count,
    output logic [dctd_pkg::COUNT_W-1:0] o_proper_choices,
    output logic                         o_prime_flag
);
    import dctd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             r_state;
    logic [VALUE_WIDTH-1:0] r_v;
    logic [VALUE_WIDTH-1:0] r_i;
    logic [VALUE_WIDTH:0]   r_sq;
    logic [COUNT_W-1:0]     r_cnt;
    logic                   r_ovf;
    logic                   r_out_valid;
    logic [COUNT_W-1:0]     r_out_cnt;
    logic [COUNT_W-1:0]     r_out_less;
    logic                   r_out_prime;

    t_rem_stat              rem_stat;
    logic                   in_fire;
    logic                   rem_start;
    logic                   out_free;
    logic [COUNT_W:0]       sum;
    logic [COUNT_W-1:0]     fin_cnt;
    logic [COUNT_W-1:0]     fin_less;

    assign in_fire   = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign rem_start = (r_state == S_CHECK) && (r_sq <= {1'b0, r_v});

    // The shared remainder unit tests one candidate at a time.
    dctd_rem #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rem_start),
        .i_dividend(r_v),
        .i_divisor (r_i),
        .o_stat    (rem_stat)
    );

    // A divisor adds two, or one when it is the exact square root.
    always_comb begin
        if (r_sq == {1'b0, r_v}) begin
            sum = {1'b0, r_cnt} + (COUNT_W + 1)'(1);
        end else begin
            sum = {1'b0, r_cnt} + (COUNT_W + 1)'(2);
        end
    end

    // Final fields, saturated when the count has run past the field.
    always_comb begin
        if (r_ovf) begin
            fin_cnt  = COUNT_MAX;
            fin_less = COUNT_MAX;
        end else begin
            fin_cnt  = r_cnt;
            fin_less = (r_cnt == '0) ? '0 : r_cnt - 1'b1;
        end
    end

    // Sequencer: check the square, divide, accumulate, then hand off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= rem_start ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Candidate, its square and the running count.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_v   <= i_n_value;
            r_i   <= VALUE_WIDTH'(1);
            r_sq  <= (VALUE_WIDTH + 1)'(1);
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if ((r_state == S_DIV) && rem_stat.done) begin
            if (rem_stat.zero) begin
                r_cnt <= sum[COUNT_W-1:0];
                if (sum[COUNT_W]) begin
                    r_ovf <= 1'b1;
                end
            end
            // (i+1)^2 = i^2 + 2i + 1
            r_sq <= r_sq + {r_i, 1'b1};
            r_i  <= r_i + 1'b1;
        end
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_cnt   <= fin_cnt;
            r_out_less  <= fin_less;
            r_out_prime <= !r_ovf && (r_cnt == COUNT_W'(2));
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_divisor_count  = r_out_cnt;
    assign o_proper_choices = r_out_less;
    assign o_prime_flag     = r_out_prime;

    // The remainder unit only works while a candidate is being tested.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !rem_stat.busy)
        else $error("remainder unit busy while idle");

    // A remainder result only arrives while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (r_state == S_DIV))
        else $error("remainder done outside the divide state");

    // An accepted item always starts at the square check.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_CHECK))
        else $error("accepted item did not start the square check");

    // A prime result has exactly two divisors.
    a_prime_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_prime) |-> (r_out_cnt == COUNT_W'(2)))
        else $error("prime flag without a count of two");

endmodule

// ===== dv/tb_divisor_count_trial_division.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_divisor_count_trial_division: self-checking bench for the divisor counter
// Offers a table of directed values and then random values over valid/ready.
// Every result item is checked field by field against a trial-division
// predictor or a typed-in result. Both sides idle at random, the receiver holds
// off long enough to back the block up; the sender waits until it has drained.
// ----------------------------------------------------------------------------
module tb_divisor_count_trial_division;

    import dctd_pkg::*;

    localparam int VW            = VALUE_WIDTH_DEF;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int NUM_DIRECTED  = 22;
    localparam int NUM_RANDOM    = 74;
    localparam int IDLE_PERCENT  = 32;
    localparam int RX_HOLD       = 3000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int REPORT_LIMIT  = 10;
    // The full-width prime is the slowest item; allow many times the
    // slowest correct run.
    localparam longint TIMEOUT_NS = 64'd300_000_000;

    // One result item as the block returns it.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] fewer;
        logic               prime;
    } divisor_result_t;

    // A result still owed by the block, with the value that caused it.
    typedef struct packed {
        logic [VW-1:0]   value;
        divisor_result_t res;
    } pending_count_t;

    // One row of the directed table; known rows carry a typed-in result.
    typedef struct packed {
        logic [VW-1:0]   value;
        logic            known;
        divisor_result_t known_res;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [VW-1:0]      i_n_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [COUNT_W-1:0] o_divisor_count;
    logic [COUNT_W-1:0] o_proper_choices;
    logic               o_prime_flag;

    pending_count_t pending_counts[$];
    stim_row_t      directed_rows[NUM_DIRECTED];

    int  errors        = 0;
    int  items_offered = 0;
    int  results_seen  = 0;
    bit  tx_no_idle    = 1'b0;
    int  hold_req      = 0;
    int  hold_done     = 0;
    int  rx_hold_left  = 0;

    divisor_count_trial_division #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_n_value       (i_n_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_divisor_count (o_divisor_count),
        .o_proper_choices(o_proper_choices),
        .o_prime_flag    (o_prime_flag)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Count the divisors of a value by trying every i with i*i <= value.
    function automatic divisor_result_t count_divisors_of(input logic [VW-1:0] v);
        longint unsigned val;
        longint unsigned i;
        int unsigned     total;
        int unsigned     fewer;
        divisor_result_t r;
        val   = 64'(v);
        total = 0;
        for (i = 1; i * i <= val; i++) begin
            if (val % i == 0) begin
                total += (i * i == val) ? 1 : 2;
            end
        end
        fewer = (total > 0) ? total - 1 : 0;
        if (total > COUNT_MAX) begin
            total = 32'(COUNT_MAX);
        end
        if (fewer > COUNT_MAX) begin
            fewer = 32'(COUNT_MAX);
        end
        r.count = total[COUNT_W-1:0];
        r.fewer = fewer[COUNT_W-1:0];
        r.prime = (total == 2);
        return r;
    endfunction

    // Count an error; only the first few are printed.
    task automatic note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Offer one item, with random idle cycles first, and wait for acceptance.
    task automatic offer_value(input logic [VW-1:0] v, input logic known,
                               input divisor_result_t known_res);
        pending_count_t p;
        while (!tx_no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_n_value <= v;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        p.value = v;
        p.res   = known ? known_res : count_divisors_of(v);
        pending_counts = {pending_counts, p};
        items_offered++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_counts.size() != 0);
    endtask

    // Receiver: check each accepted result, then choose ready for the next cycle.
    always @(posedge i_clk) begin
        pending_count_t p;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_counts.size() == 0) begin
                note_error($sformatf("result with nothing owed: count=%0d fewer=%0d prime=%0b",
                                     o_divisor_count, o_proper_choices, o_prime_flag));
            end else begin
                p = pending_counts.pop_front();
                if (o_divisor_count !== p.res.count || o_proper_choices !== p.res.fewer
                        || o_prime_flag !== p.res.prime) begin
                    note_error($sformatf(
                        "n=%0d: expected count=%0d fewer=%0d prime=%0b, got %0d %0d %0b",
                        p.value, p.res.count, p.res.fewer, p.res.prime,
                        o_divisor_count, o_proper_choices, o_prime_flag));
                end
            end
        end
        // A requested hold-off keeps ready low for a long counted stretch.
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done    = hold_req;
            rx_hold_left = RX_HOLD - 1;
            i_ready     <= 1'b0;
        end else if (results_seen >= 45 && results_seen < 75) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_divisor_count_trial_division: FAIL");
        $finish;
    end

    // Stimulus: reset, directed table, random values, then the final verdict.
    initial begin : stimulus
        int              k;
        int              j;
        int unsigned     pick;
        int unsigned     root;
        logic [VW-1:0]   v;
        divisor_result_t none;
        none = '0;
        // Zero, one, two and the full-width Mersenne prime are typed in.
        directed_rows = '{
            '{31'd0,          1'b1, '{11'd0, 11'd0, 1'b0}},
            '{31'd1,          1'b1, '{11'd1, 11'd0, 1'b0}},
            '{31'd2,          1'b1, '{11'd2, 11'd1, 1'b1}},
            '{31'd3,          1'b0, '0},
            '{31'd4,          1'b0, '0},
            '{31'd6,          1'b0, '0},
            '{31'd9,          1'b0, '0},
            '{31'd12,         1'b0, '0},
            '{31'd16,         1'b0, '0},
            '{31'd25,         1'b0, '0},
            '{31'd36,         1'b0, '0},
            '{31'd49,         1'b0, '0},
            '{31'd97,         1'b0, '0},
            '{31'd100,        1'b0, '0},
            '{31'd128,        1'b0, '0},
            '{31'd1024,       1'b0, '0},
            '{31'd5040,       1'b0, '0},
            '{31'd65521,      1'b0, '0},
            '{31'd720720,     1'b0, '0},
            '{31'd999983,     1'b0, '0},
            '{31'd1048576,    1'b0, '0},
            '{31'h7FFF_FFFF,  1'b1, '{11'd2, 11'd1, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_DIRECTED; k++) begin
            offer_value(directed_rows[k].value, directed_rows[k].known,
                        directed_rows[k].known_res);
        end
        wait_for_drain();

        // Random values: mostly small, some squares, a few below 2^20.
        for (k = 0; k < NUM_RANDOM; k++) begin
            tx_no_idle = (k >= 40 && k < 70);
            if (k == 25) begin
                // Back the block up: tiny items offered back to back while
                // the receiver holds off.
                wait_for_drain();
                hold_req++;
                tx_no_idle = 1'b1;
                for (j = 0; j < 4; j++) begin
                    offer_value(VW'($urandom_range(0, 63)), 1'b0, none);
                end
                tx_no_idle = 1'b0;
            end
            if (k == 60) begin
                wait_for_drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                v = VW'($urandom_range(0, 1023));
            end else if (pick < 75) begin
                v = VW'($urandom_range(0, 16383));
            end else if (pick < 90) begin
                root = $urandom_range(0, 255);
                v = VW'(root * root);
            end else begin
                v = VW'($urandom_range(0, (1 << 20) - 1));
            end
            offer_value(v, 1'b0, none);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            note_error($sformatf("%0d results never arrived", pending_counts.size()));
        end

        $display("Summary: %0d items offered, from zero and one up to the full-width prime,",
                 items_offered);
        $display("         with squares, primes and a backed-up receiver; %0d results, %0d errors.",
                 results_seen, errors);
        if (errors == 0) begin
            $display("tb_divisor_count_trial_division: PASS");
        end else begin
            $display("tb_divisor_count_trial_division: FAIL");
        end
        $finish;
    end

endmodule
